// File: rtl/core/flare_pkg.sv
// Shared types, codes and constants for the flare fade tracker.
`timescale 1ns / 1ps
package flare_pkg;

  localparam int unsigned FLARE_SLOTS_DEF = 64;
  localparam logic [15:0] FADE_STEP_RST   = 16'd459;
  localparam logic        ENABLE_RST      = 1'b1;
  localparam logic [31:0] FADE_BACK_MS    = 32'd2000;
  localparam logic [16:0] FRAC_ONE        = 17'd65536;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [1:0] ADD_REFRESH = 2'd0;
  localparam logic [1:0] ADD_NEW     = 2'd1;
  localparam logic [1:0] ADD_DROP    = 2'd2;

  localparam logic CFG_FADE_STEP = 1'b0;
  localparam logic CFG_ENABLE    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_DRAIN,
    S_A_WRITE,
    S_R_READ,
    S_R_EVAL,
    S_R_FIN,
    S_R_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  scene;
    logic        portal;
    logic [31:0] added;
    logic        shown;
    logic        cv;
    logic [31:0] fade;
  } rec_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic cnt_inc;
    logic add_commit;
    logic r_eval;
    logic r_fin;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic enabled;
    logic cnt_last;
    logic out_busy;
    logic pend_valid;
    logic fin_draw;
  } sts_t;

endpackage

// File: rtl/core/flare_fade_tracker_unit.sv
// Top level of the flare fade tracker.
// Keeps FLARE_SLOTS flare slots in a table with one read and one write
// port, walked one slot at a time. An add request scans every slot, waits
// out any output stall and returns one status. A render request reads,
// fade-multiplies, then clamps and updates each slot in turn, holding for
// any output stall, and returns one draw result per visible flare with last
// on the final one; with flares disabled it completes at once with no
// result. Slot validity resets to empty; no clearing pass is needed.
`timescale 1ns / 1ps
module flare_fade_tracker_unit #(
  parameter int unsigned FLARE_SLOTS = flare_pkg::FLARE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] flare_id,
  input  logic [7:0]  scene_num,
  input  logic        in_portal,
  input  logic        cg_visible,
  input  logic [31:0] frame_num,
  input  logic [31:0] time_ms,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  add_status,
  output logic [5:0]  slot,
  output logic [15:0] out_id,
  output logic [7:0]  intensity,
  output logic        last
);
  import flare_pkg::*;

  cmd_t cmd;
  sts_t sts;

  flare_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  flare_datapath #(.FLARE_SLOTS(FLARE_SLOTS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .flare_id   (flare_id),
    .scene_num  (scene_num),
    .in_portal  (in_portal),
    .cg_visible (cg_visible),
    .frame_num  (frame_num),
    .time_ms    (time_ms),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .add_status (add_status),
    .slot       (slot),
    .out_id     (out_id),
    .intensity  (intensity),
    .last       (last)
  );

endmodule

// File: rtl/core/flare_ctrl.sv
// Sequencer for add lookups and render passes over the flare slots.
`timescale 1ns / 1ps
module flare_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  flare_pkg::sts_t sts,
  output flare_pkg::cmd_t cmd
);
  import flare_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.action == ACT_ADD) begin
            state_next = S_A_SCAN;
          end else if (sts.enabled) begin
            state_next = S_R_READ;
          end
        end
      end
      S_A_SCAN:  if (sts.cnt_last) state_next = S_A_DRAIN;
      S_A_DRAIN: state_next = S_A_WRITE;
      S_A_WRITE: if (!sts.out_busy) state_next = S_IDLE;
      S_R_READ:  state_next = S_R_EVAL;
      S_R_EVAL:  state_next = S_R_FIN;
      S_R_FIN: begin
        if (!(sts.fin_draw && sts.pend_valid && sts.out_busy)) begin
          state_next = sts.cnt_last ? S_R_FLUSH : S_R_READ;
        end
      end
      S_R_FLUSH: if (!(sts.pend_valid && sts.out_busy)) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_A_SCAN: begin
        cmd.scan = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_A_DRAIN: ;
      S_A_WRITE: cmd.add_commit = !sts.out_busy;
      S_R_READ:  ;
      S_R_EVAL:  cmd.r_eval = 1'b1;
      S_R_FIN: begin
        if (!(sts.fin_draw && sts.pend_valid && sts.out_busy)) begin
          cmd.r_fin = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_R_FLUSH: cmd.flush = !(sts.pend_valid && sts.out_busy);
      default:   ;
    endcase
  end

endmodule

// File: rtl/core/flare_datapath.sv
// Slot table, fade arithmetic and result registers of the flare tracker.
`timescale 1ns / 1ps
module flare_datapath #(
  parameter int unsigned FLARE_SLOTS = flare_pkg::FLARE_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            action,
  input  logic [15:0]     flare_id,
  input  logic [7:0]      scene_num,
  input  logic            in_portal,
  input  logic            cg_visible,
  input  logic [31:0]     frame_num,
  input  logic [31:0]     time_ms,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  input  flare_pkg::cmd_t cmd,
  output flare_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            kind,
  output logic [1:0]      add_status,
  output logic [5:0]      slot,
  output logic [15:0]     out_id,
  output logic [7:0]      intensity,
  output logic            last
);
  import flare_pkg::*;

  localparam int unsigned IDX_W = $clog2(FLARE_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FLARE_SLOTS - 1);

  logic [15:0] fade_step;
  logic        enabled;

  logic        r_portal, r_cgvis;
  logic [15:0] r_id;
  logic [7:0]  r_scene;
  logic [31:0] r_frame, r_now, prev_frame;

  logic [IDX_W-1:0]   cnt;
  logic [FLARE_SLOTS-1:0] valid;
  rec_t mem [FLARE_SLOTS];
  rec_t mem_q;

  logic             chk_en;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_valid, chk_match;
  logic             hit_found, free_found;
  logic [IDX_W-1:0] hit_idx, free_idx;
  rec_t             hit_rec;

  rec_t  add_rec;
  logic  add_write;
  logic [IDX_W-1:0] add_idx;

  rec_t               e_rec;
  logic               e_valid, e_stale, e_match;
  logic signed [48:0] prod;
  rec_t               upd_rec;
  logic [31:0]        elapsed;
  logic               stale_now;

  logic signed [49:0] frac_raw;
  logic [16:0]        frac;
  logic [24:0]        scaled;
  logic               fin_draw, fin_free, fin_write;

  logic             pend_valid;
  logic [IDX_W-1:0] pend_slot;
  logic [15:0]      pend_id;
  logic [7:0]       pend_int;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_rec;

  assign prev_frame = r_frame - 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_step <= FADE_STEP_RST;
      enabled   <= ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FADE_STEP: fade_step <= cfg_data;
        CFG_ENABLE:    enabled   <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_id     <= flare_id;
      r_scene  <= scene_num;
      r_portal <= in_portal;
      r_cgvis  <= cg_visible;
      r_frame  <= frame_num;
      r_now    <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= (cnt == IDX_LAST) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    mem_q <= mem[cnt];
  end

  // add lookup: compare one slot behind the read address
  assign chk_valid = valid[chk_idx];
  assign chk_match = chk_valid && mem_q.id == r_id && mem_q.scene == r_scene &&
                     mem_q.portal == r_portal;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_en     <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      chk_en <= cmd.scan;
      if (cmd.load) begin
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (chk_en) begin
        if (chk_match && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!chk_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= cnt;
    if (chk_en && chk_match && !hit_found) begin
      hit_idx <= chk_idx;
      hit_rec <= mem_q;
    end
    if (chk_en && !chk_valid && !free_found) begin
      free_idx <= chk_idx;
    end
  end

  always_comb begin
    if (hit_found) begin
      add_rec = hit_rec;
    end else begin
      add_rec = '0;
      add_rec.id     = r_id;
      add_rec.scene  = r_scene;
      add_rec.portal = r_portal;
    end
    add_rec.cv = r_cgvis;
    if (!hit_found || hit_rec.added != prev_frame) begin
      add_rec.shown = 1'b0;
      add_rec.fade  = r_now - FADE_BACK_MS;
    end
    add_rec.added = r_frame;
  end

  assign add_write = hit_found || free_found;
  assign add_idx   = hit_found ? hit_idx : free_idx;

  // render: visibility update and fade product
  always_comb begin
    upd_rec = mem_q;
    if (mem_q.cv != mem_q.shown) begin
      upd_rec.shown = mem_q.cv;
      upd_rec.fade  = r_now - 32'd1;
    end
  end

  assign elapsed   = r_now - upd_rec.fade;
  assign stale_now = (mem_q.added - prev_frame) >> 31 != 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.r_eval) begin
      e_rec   <= upd_rec;
      e_valid <= valid[cnt];
      e_stale <= stale_now;
      e_match <= mem_q.scene == r_scene && mem_q.portal == r_portal;
      prod    <= $signed(elapsed) * $signed({1'b0, fade_step});
    end
  end

  always_comb begin
    frac_raw = e_rec.cv ? {prod[48], prod} : 50'sd65536 - {prod[48], prod};
    if (frac_raw < 50'sd0) begin
      frac = '0;
    end else if (frac_raw > 50'sd65536) begin
      frac = FRAC_ONE;
    end else begin
      frac = frac_raw[16:0];
    end
    scaled = {frac, 8'd0} - {8'd0, frac};
  end

  assign fin_write = e_valid && !e_stale && e_match;
  assign fin_draw  = fin_write && frac != '0;
  assign fin_free  = e_valid && (e_stale || (e_match && frac == '0));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_rec  = e_rec;
    if (cmd.add_commit) begin
      wr_en   = add_write;
      wr_addr = add_idx;
      wr_rec  = add_rec;
    end else if (cmd.r_fin) begin
      wr_en = fin_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.add_commit && !hit_found && free_found) begin
      valid[free_idx] <= 1'b1;
    end else if (cmd.r_fin && fin_free) begin
      valid[cnt] <= 1'b0;
    end
  end

  // hold the latest draw until the next one shows whether it closes the pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load || cmd.flush) begin
      pend_valid <= 1'b0;
    end else if (cmd.r_fin && fin_draw) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.r_fin && fin_draw) begin
      pend_slot <= cnt;
      pend_id   <= e_rec.id;
      pend_int  <= scaled[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.add_commit || (cmd.r_fin && fin_draw && pend_valid) ||
                 (cmd.flush && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      kind       <= KIND_ADD;
      add_status <= hit_found ? ADD_REFRESH : (free_found ? ADD_NEW : ADD_DROP);
      slot       <= add_write ? 6'(add_idx) : 6'd0;
      out_id     <= r_id;
      intensity  <= 8'd0;
      last       <= 1'b1;
    end else if ((cmd.r_fin && fin_draw && pend_valid) || (cmd.flush && pend_valid)) begin
      kind       <= KIND_DRAW;
      add_status <= ADD_REFRESH;
      slot       <= 6'(pend_slot);
      out_id     <= pend_id;
      intensity  <= pend_int;
      last       <= cmd.flush;
    end
  end

  assign sts.action     = action;
  assign sts.enabled    = enabled;
  assign sts.cnt_last   = cnt == IDX_LAST;
  assign sts.out_busy   = out_valid;
  assign sts.pend_valid = pend_valid;
  assign sts.fin_draw   = fin_draw;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the flare fade tracker: random and directed requests, slot table predictor.
`timescale 1ns / 1ps
module testbench;
  import flare_pkg::*;

  localparam int SLOTS = 64;
  localparam int LIMIT = 2000000;
  localparam int SETTLE = 3 * SLOTS + 20;

  typedef struct {
    logic        act;
    logic [15:0] id;
    logic [7:0]  scene;
    logic        portal;
    logic        vis;
    logic [31:0] frame;
    logic [31:0] tms;
  } flare_req_t;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] id;
    logic [7:0]  inten;
    logic        last;
  } flare_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [15:0] flare_id = '0;
  logic [7:0] scene_num = '0;
  logic in_portal = 1'b0;
  logic cg_visible = 1'b0;
  logic [31:0] frame_num = '0;
  logic [31:0] time_ms = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [1:0] add_status;
  logic [5:0] slot;
  logic [15:0] out_id;
  logic [7:0] intensity;
  logic last;

  flare_req_t pending_reqs[$];
  flare_res_t expected_results[$];
  flare_req_t cur_req;
  int errors = 0;
  int cycles = 0;
  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;

  logic [15:0] step_m = FADE_STEP_RST;
  logic        enabled_m = ENABLE_RST;
  logic        tv_valid[SLOTS];
  logic [15:0] tv_id[SLOTS];
  logic [7:0]  tv_scene[SLOTS];
  logic        tv_portal[SLOTS];
  logic [31:0] tv_added[SLOTS];
  logic        tv_shown[SLOTS];
  logic        tv_cv[SLOTS];
  logic [31:0] tv_fade[SLOTS];

  logic [31:0] fr;
  logic [31:0] tm;

  flare_fade_tracker_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_result(logic k, logic [1:0] st, int s, logic [15:0] id,
                                      logic [7:0] inten, logic lst);
    flare_res_t r;
    r.kind = k; r.status = st; r.slot = s[5:0]; r.id = id; r.inten = inten; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void track_flares(flare_req_t r);
    int hit, free_s, n;
    logic fresh;
    logic [31:0] prev;
    longint elapsed, frac;
    hit = -1; free_s = -1; n = 0; fresh = 1'b0;
    prev = r.frame - 32'd1;
    if (r.act == ACT_ADD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (tv_valid[i]) begin
          if (hit < 0 && tv_id[i] == r.id && tv_scene[i] == r.scene && tv_portal[i] == r.portal)
            hit = i;
        end else if (free_s < 0) begin
          free_s = i;
        end
      end
      if (hit < 0 && free_s < 0) begin
        push_result(KIND_ADD, ADD_DROP, 0, r.id, 8'd0, 1'b1);
        return;
      end
      if (hit < 0) begin
        hit = free_s; fresh = 1'b1;
        tv_valid[hit] = 1'b1; tv_id[hit] = r.id; tv_scene[hit] = r.scene;
        tv_portal[hit] = r.portal;
      end
      tv_cv[hit] = r.vis;
      if (fresh || tv_added[hit] != prev) begin
        tv_shown[hit] = 1'b0;
        tv_fade[hit] = r.tms - FADE_BACK_MS;
      end
      tv_added[hit] = r.frame;
      push_result(KIND_ADD, fresh ? ADD_NEW : ADD_REFRESH, hit, r.id, 8'd0, 1'b1);
      return;
    end
    if (!enabled_m) return;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tv_valid[i]) continue;
      if (tv_added[i] - prev >= 32'h8000_0000) begin
        tv_valid[i] = 1'b0;
        continue;
      end
      if (tv_scene[i] != r.scene || tv_portal[i] != r.portal) continue;
      if (tv_cv[i] != tv_shown[i]) begin
        tv_shown[i] = tv_cv[i];
        tv_fade[i] = r.tms - 32'd1;
      end
      elapsed = longint'(signed'(r.tms - tv_fade[i]));
      frac = elapsed * longint'(step_m);
      if (!tv_cv[i]) frac = 65536 - frac;
      if (frac < 0) frac = 0;
      if (frac > 65536) frac = 65536;
      if (frac == 0) begin
        tv_valid[i] = 1'b0;
        continue;
      end
      push_result(KIND_DRAW, ADD_REFRESH, i, tv_id[i], 8'((frac * 255) >>> 16), 1'b0);
      n++;
    end
    if (n > 0) expected_results[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_flares(cur_req);
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 9) != 0)) begin
          cur_req = pending_reqs.pop_front();
          action <= cur_req.act;
          flare_id <= cur_req.id;
          scene_num <= cur_req.scene;
          in_portal <= cur_req.portal;
          cg_visible <= cur_req.vis;
          frame_num <= cur_req.frame;
          time_ms <= cur_req.tms;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_seen <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_cnt <= 600;
      hold_seen <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    flare_res_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d id %0d", kind, slot, out_id);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("kind", e.kind, kind);
          check_field("add_status", e.status, add_status);
          check_field("slot", e.slot, slot);
          check_field("out_id", e.id, out_id);
          check_field("intensity", e.inten, intensity);
          check_field("last", e.last, last);
        end
      end
      out_stall <= (hold_cnt != 0) || (!quiet && $urandom_range(0, 9) == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL flare_fade_tracker_unit");
      $finish;
    end
  end

  task automatic queue_req(logic act, logic [15:0] id, logic [7:0] sc, logic p, logic v,
                           logic [31:0] f, logic [31:0] t);
    flare_req_t r;
    r.act = act; r.id = id; r.scene = sc; r.portal = p; r.vis = v; r.frame = f; r.tms = t;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FADE_STEP) step_m = val;
    else enabled_m = val[0];
  endtask

  // Frames of adds from a small id pool followed by a render, with some noise.
  task automatic queue_frames(int n);
    int k;
    logic [7:0] sc;
    logic p;
    while (n > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_req(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom);
        n--;
        continue;
      end
      sc = 8'($urandom_range(0, 2));
      p = ($urandom_range(0, 5) == 0);
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) begin
        queue_req(ACT_ADD, ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : sc,
                  ($urandom_range(0, 5) == 0) ? !p : p, 1'($urandom_range(0, 1)), fr, tm);
      end
      queue_req(ACT_RENDER, 16'($urandom), sc, p, 1'($urandom_range(0, 1)), fr, tm);
      n -= k + 1;
      fr += ($urandom_range(0, 15) == 0) ? 32'($urandom_range(2, 5)) : 32'd1;
      tm += ($urandom_range(0, 15) == 0) ? 32'($urandom) : 32'($urandom_range(0, 250));
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) tv_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_req(ACT_ADD, 16'h0000, 8'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0);
    queue_req(ACT_ADD, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0);
    queue_req(ACT_RENDER, 16'hFFFF, 8'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0);
    queue_req(ACT_ADD, 16'h0000, 8'd0, 1'b0, 1'b1, 32'd0, 32'd100);
    queue_req(ACT_ADD, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF);
    queue_req(ACT_RENDER, 16'h0, 8'hFF, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF);
    queue_req(ACT_RENDER, 16'h0, 8'd0, 1'b0, 1'b0, 32'd0, 32'd200);
    queue_req(ACT_ADD, 16'h0000, 8'd0, 1'b0, 1'b0, 32'd1, 32'd300);
    queue_req(ACT_RENDER, 16'h0, 8'd0, 1'b0, 1'b0, 32'd1, 32'd301);
    queue_req(ACT_RENDER, 16'h0, 8'd0, 1'b0, 1'b0, 32'd5, 32'd2000);
    queue_req(ACT_RENDER, 16'h0, 8'd7, 1'b0, 1'b0, 32'd5, 32'd2000);
    fr = 32'd10; tm = 32'd5000;
    queue_frames(130);
    drain();

    write_cfg(CFG_FADE_STEP, 16'hFFFF);
    for (int i = 0; i < SLOTS + 3; i++)
      queue_req(ACT_ADD, 16'(i + 100), 8'd4, 1'b0, i[0], fr, tm);
    queue_req(ACT_RENDER, 16'h0, 8'd4, 1'b0, 1'b0, fr, tm + 32'd1);
    fr += 32'd1; tm += 32'd2;
    drain();

    write_cfg(CFG_FADE_STEP, 16'd0);
    queue_frames(30);
    drain();
    write_cfg(CFG_ENABLE, 16'd0);
    queue_frames(30);
    drain();

    write_cfg(CFG_ENABLE, 16'd1);
    write_cfg(CFG_FADE_STEP, 16'($urandom_range(100, 2000)));
    queue_frames(60);
    hold_go = 1'b1;
    quiet = 1'b1;
    drain();
    quiet = 1'b0;
    write_cfg(CFG_FADE_STEP, FADE_STEP_RST);
    queue_frames(120);
    drain();

    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS flare_fade_tracker_unit");
    end else begin
      $display("FAIL flare_fade_tracker_unit");
    end
    $finish;
  end

endmodule

// File: flare_fade_tracker_unit.f
rtl/core/flare_pkg.sv
rtl/core/flare_ctrl.sv
rtl/core/flare_datapath.sv
rtl/core/flare_fade_tracker_unit.sv
bench/testbench.sv
